// ===== hdl/frame_rate_limiter_per_output_unit_defines.svh =====
// Assertion macros used by the frame rate limiter top level.
`ifndef FRAME_RATE_LIMITER_PER_OUTPUT_UNIT_DEFINES_SVH
`define FRAME_RATE_LIMITER_PER_OUTPUT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FRL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FRL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/frl_pkg.sv =====
// Types and constants shared by the frame rate limiter cells and top level.
package frl_pkg;

   // Table size and field widths.
   localparam int NUM_OUTPUTS = 4;
   localparam int IDX_W       = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int SEL_W       = 2;
   localparam int CMP_W       = (IDX_W > SEL_W) ? IDX_W : SEL_W;
   localparam int MASK_W      = 4;
   localparam int TIME_W      = 48;
   localparam int HASH_W      = 32;
   localparam int IVAL_W      = 32;
   localparam int WAIT_W      = 32;
   // Due time is a 48-bit time plus a 32-bit interval.
   localparam int DUE_W       = TIME_W + 1;
   localparam int DIFF_W      = DUE_W + 1;
   localparam logic [WAIT_W-1:0] WAIT_NONE = '1;

   // Item kinds.
   typedef enum logic [1:0] {
      MODE_POLL    = 2'd0,
      MODE_FRAME   = 2'd1,
      MODE_ENABLE  = 2'd2,
      MODE_DISABLE = 2'd3
   } mode_type;

   // One accepted input word, held while it runs down the chain.
   typedef struct packed {
      mode_type           mode;
      logic [TIME_W-1:0]  now_ms;
      logic [HASH_W-1:0]  frame_hash;
      logic [SEL_W-1:0]   output_index;
      logic [IVAL_W-1:0]  interval_ms;
   } item_type;

   // What one cell hands to its neighbor: the token and the partial result.
   typedef struct packed {
      logic               valid;
      logic [MASK_W-1:0]  send_mask;
      logic [WAIT_W-1:0]  wait_ms;
   } link_type;

endpackage

// ===== hdl/frame_rate_limiter_per_output_unit.sv =====
// Top level of the per-output frame rate limiter: item register and cell chain.
//
// Usage: drive the req_ fields and raise start; a word is taken at a clock
// edge where start is high and busy is low. Modes: poll, frame offered,
// enable output, disable output. Exactly one result word follows each item:
// rsp_strobe is high for one cycle with rsp_send_mask and rsp_wait_ms.
// The receiver cannot stall, so the result must be captured in that cycle.
// The strobe is driven by the last cell's link register once the item has
// passed the launch register and every cell in turn; the item walks the
// chain of output cells, one cell per cycle, each cell updating its own
// output and folding its wait and mask bit into the word it passes on.
// busy drops in the cycle the strobe is shown, so the next item may be
// accepted at the edge that takes the result.
// Reset (synchronous, active high) disables every output and clears all
// intervals, times, hashes and skip flags; no result is pending afterward.
// With no output enabled the reported wait is all ones.
`include "frame_rate_limiter_per_output_unit_defines.svh"

module frame_rate_limiter_per_output_unit import frl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [HASH_W-1:0] req_frame_hash,
   input  logic [SEL_W-1:0]  req_output_index,
   input  logic [IVAL_W-1:0] req_interval_ms,
   output logic              rsp_strobe,
   output logic [MASK_W-1:0] rsp_send_mask,
   output logic [WAIT_W-1:0] rsp_wait_ms
);

   item_type               item_ff, item_in;
   logic                   launch_ff, launch_in;
   logic                   accept;
   link_type               link [NUM_OUTPUTS+1];
   logic [NUM_OUTPUTS-1:0] in_flight;
   logic                   non_frame_rsp;

   assign accept = start && !busy;

   // Capture the input word; it stays put until the chain is done with it.
   always_comb begin
      item_in.mode         = mode_type'(req_mode);
      item_in.now_ms       = req_now_ms;
      item_in.frame_hash   = req_frame_hash;
      item_in.output_index = req_output_index;
      item_in.interval_ms  = req_interval_ms;
   end

   assign launch_in = accept;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= launch_in;
      end
   end

   // The first cell starts from an empty mask and an all-ones wait.
   always_comb begin
      link[0].valid     = launch_ff;
      link[0].send_mask = '0;
      link[0].wait_ms   = WAIT_NONE;
   end

   // Chain of output cells.
   for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_cell
      frl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .item       (item_ff),
         .link_in    (link[i]),
         .link_out   (link[i+1])
      );
   end

   // Busy while a token is still ahead of the last cell.
   for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_flight
      assign in_flight[i] = link[i].valid;
   end

   assign busy          = |in_flight;
   assign rsp_strobe    = link[NUM_OUTPUTS].valid;
   assign rsp_send_mask = link[NUM_OUTPUTS].send_mask;
   assign rsp_wait_ms   = link[NUM_OUTPUTS].wait_ms;

   assign non_frame_rsp = rsp_strobe && (item_ff.mode != MODE_FRAME);

   `FRL_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
   `FRL_ASSERT_IMP(a_one_token, 1'b1, $onehot0({in_flight, rsp_strobe}), "two items in chain")
   `FRL_ASSERT_IMP(a_mask_frame_only, non_frame_rsp, rsp_send_mask == '0, "mask on non-frame")
   `FRL_ASSERT_IMP(a_no_accept_busy, busy, !accept, "item accepted while busy")

endmodule

// ===== hdl/frl_cell.sv =====
// One output of the limiter table: its state, update and partial wait/mask.
module frl_cell import frl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  item_type         item,
   input  link_type         link_in,
   output link_type         link_out
);

   // Per-output state; deadline holds last send or skip time plus interval (the interval alone after enable).
   logic              enabled_ff, enabled_in;
   logic [IVAL_W-1:0] interval_ff, interval_in;
   logic [DUE_W-1:0]  deadline_ff, deadline_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              skipped_ff, skipped_in;
   link_type          link_ff, link_next_in;

   logic              active;
   logic              hit;
   logic              is_frame;
   logic              is_enable;
   logic              is_disable;
   logic [IVAL_W-1:0] new_interval;
   logic [DUE_W-1:0]  due_operand;
   logic [DIFF_W-1:0] diff;
   logic              due;
   logic              hash_changed;
   logic              send;
   logic              skip;
   logic              enabled_after;
   logic [WAIT_W-1:0] cell_wait;
   logic [DUE_W-1:0]  restart_due;

   assign active = link_in.valid;
   assign hit    = (CMP_W'(item.output_index) == CMP_W'(cell_index));

   // Decode the item kind for this cell's turn.
   always_comb begin
      is_frame   = 1'b0;
      is_enable  = 1'b0;
      is_disable = 1'b0;
      case (item.mode)
         MODE_POLL:    ;
         MODE_FRAME:   is_frame   = active && enabled_ff;
         MODE_ENABLE:  is_enable  = active && hit;
         MODE_DISABLE: is_disable = active && hit;
         default:      ;
      endcase
   end

   // Enabling an enabled output keeps the smaller interval.
   assign new_interval = (enabled_ff && (interval_ff < item.interval_ms)) ?
                         interval_ff : item.interval_ms;

   // One subtractor serves both the due test and the remaining wait.
   assign due_operand = is_enable ? DUE_W'(new_interval) : deadline_ff;
   assign diff        = DIFF_W'(due_operand) - DIFF_W'(item.now_ms);
   assign due         = diff[DIFF_W-1] || (diff == '0);

   assign hash_changed = (item.frame_hash != hash_ff);
   assign send         = is_frame && hash_changed && (due || skipped_ff);
   assign skip         = is_frame && !hash_changed && due;
   assign restart_due  = DUE_W'(item.now_ms) + DUE_W'(interval_ff);

   // Wait of this output after the update, saturated to 32 bits.
   always_comb begin
      if (send || skip) begin
         cell_wait = interval_ff;
      end else if (due) begin
         cell_wait = '0;
      end else if (|diff[DUE_W-1:WAIT_W]) begin
         cell_wait = WAIT_NONE;
      end else begin
         cell_wait = diff[WAIT_W-1:0];
      end
   end

   always_comb begin
      if (is_enable) begin
         enabled_after = 1'b1;
      end else if (is_disable) begin
         enabled_after = 1'b0;
      end else begin
         enabled_after = enabled_ff;
      end
   end

   // Fold this output into the running minimum and mask.
   always_comb begin
      link_next_in.valid     = active;
      link_next_in.send_mask = link_in.send_mask |
                               (send ? (MASK_W'(1) << cell_index) : '0);
      if (enabled_after && (cell_wait < link_in.wait_ms)) begin
         link_next_in.wait_ms = cell_wait;
      end else begin
         link_next_in.wait_ms = link_in.wait_ms;
      end
   end

   // State update for enable, disable, send and skip.
   always_comb begin
      enabled_in  = enabled_after;
      interval_in = interval_ff;
      deadline_in = deadline_ff;
      hash_in     = hash_ff;
      skipped_in  = skipped_ff;
      if (is_enable) begin
         interval_in = new_interval;
         deadline_in = DUE_W'(new_interval);
         hash_in     = '0;
         skipped_in  = 1'b0;
      end else if (send) begin
         deadline_in = restart_due;
         hash_in     = item.frame_hash;
         skipped_in  = 1'b0;
      end else if (skip) begin
         deadline_in = restart_due;
         skipped_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         interval_ff <= '0;
         deadline_ff <= '0;
         hash_ff     <= '0;
         skipped_ff  <= 1'b0;
         link_ff     <= '0;
      end else begin
         enabled_ff  <= enabled_in;
         interval_ff <= interval_in;
         deadline_ff <= deadline_in;
         hash_ff     <= hash_in;
         skipped_ff  <= skipped_in;
         link_ff     <= link_next_in;
      end
   end

   assign link_out = link_ff;

endmodule
